@@ design/dfas_pkg.sv @@
// Shared types and constants for the dual-family address set.
package dfas_pkg;

  // Number of address slots held in the set.
  localparam int SLOTS = 16;

  // Slot index and valid-count widths derived from the slot count.
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_W = $clog2(SLOTS + 1);

  // Fixed port widths of the result fields.
  localparam int OUT_SLOT_W  = 6;
  localparam int OUT_COUNT_W = 7;

  // IPv4 addresses occupy the low 32 bits of the low word.
  localparam int V4_W = 32;

  typedef logic [63:0]        word_t;
  typedef logic [SLOT_W-1:0]  slot_idx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SLOTS-1:0]   flags_t;
  typedef word_t              word_arr_t [SLOTS];

  // Address offered by one request.
  typedef struct packed {
    logic  is_v6;
    word_t addr_low;
    word_t addr_high;
  } req_t;

  // Lookup outcome from the compare array.
  typedef struct packed {
    logic      hit;
    slot_idx_t idx;
  } match_t;

  // Pointer and occupancy of the slot store.
  typedef struct packed {
    slot_idx_t next_slot;
    count_t    used;
    count_t    used_after_add;
  } status_t;

endpackage

@@ design/dfas_match.sv @@
// Parallel compare of one address against all valid slots, lowest hit wins.
module dfas_match (
  input  dfas_pkg::req_t      req,
  input  dfas_pkg::word_arr_t lo_q,
  input  dfas_pkg::word_arr_t hi_q,
  input  dfas_pkg::flags_t    flags,
  input  dfas_pkg::count_t    used,
  output dfas_pkg::match_t    match
);
  import dfas_pkg::*;

  flags_t hits;

  // Per-slot compare; only slots below the fill count are valid.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      logic fam_ok;
      logic addr_ok;
      fam_ok  = (flags[i] == req.is_v6);
      if (req.is_v6) begin
        addr_ok = (lo_q[i] == req.addr_low) && (hi_q[i] == req.addr_high);
      end else begin
        addr_ok = (lo_q[i][V4_W-1:0] == req.addr_low[V4_W-1:0]);
      end
      hits[i] = fam_ok && addr_ok && (COUNT_W'(i) < used);
    end
  end

  // Priority encode toward the lowest slot.
  always_comb begin
    match.hit = |hits;
    match.idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        match.idx = SLOT_W'(i);
      end
    end
  end

endmodule

@@ design/dfas_store.sv @@
// Slot storage with round-robin write pointer and saturating fill count.
module dfas_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  dfas_pkg::req_t      req,
  output dfas_pkg::word_arr_t lo_q,
  output dfas_pkg::word_arr_t hi_q,
  output dfas_pkg::flags_t    flags,
  output dfas_pkg::status_t   status
);
  import dfas_pkg::*;

  slot_idx_t next_slot;
  slot_idx_t next_slot_next;
  count_t    used;
  count_t    used_next;

  // Pointer wrap and count saturation.
  always_comb begin
    next_slot_next = (next_slot == SLOT_W'(SLOTS - 1)) ? '0 : next_slot + 1'b1;
    used_next      = (used < COUNT_W'(SLOTS)) ? used + 1'b1 : used;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
      used      <= '0;
      flags     <= '0;
    end else if (wr_en) begin
      next_slot        <= next_slot_next;
      used             <= used_next;
      flags[next_slot] <= req.is_v6;
    end
  end

  // Address words; IPv4 keeps the low 32 bits, zero-extended, high word cleared.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (req.is_v6) begin
        lo_q[next_slot] <= req.addr_low;
        hi_q[next_slot] <= req.addr_high;
      end else begin
        lo_q[next_slot] <= {{(64 - V4_W){1'b0}}, req.addr_low[V4_W-1:0]};
        hi_q[next_slot] <= '0;
      end
    end
  end

  assign status.next_slot      = next_slot;
  assign status.used           = used;
  assign status.used_after_add = used_next;

endmodule

@@ design/dual_family_address_set.sv @@
// Top level of the dual-family address set: input stage, lookup, result stage.
//
// Usage:
//   Requests arrive on in_valid/in_ready with is_v6, addr_low and addr_high.
//   Each request yields exactly one result on out_valid/out_ready carrying
//   added (1 when stored, 0 for a duplicate), slot (slot written or slot of
//   the duplicate) and valid_count (valid slots after the request).
//   An accepted request sits in the input register, where it is compared
//   against every valid slot in parallel and the store is updated; its
//   result is then registered. One request per cycle is sustained while
//   the receiver keeps taking results, set by the compare and pointer update
//   that carries state from one request to the next.
//   A stalled receiver holds the result register; the input register then
//   holds its request and in_ready drops until the result is taken.
//   Synchronous reset empties the set: fill count, write pointer and family
//   tags go to zero and both stages are emptied. Address words need no reset.
module dual_family_address_set (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                is_v6,
  input  dfas_pkg::word_t                     addr_low,
  input  dfas_pkg::word_t                     addr_high,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                added,
  output logic [dfas_pkg::OUT_SLOT_W-1:0]     slot,
  output logic [dfas_pkg::OUT_COUNT_W-1:0]    valid_count
);
  import dfas_pkg::*;

  logic      s1_valid;
  req_t      s1_req;
  logic      s1_adv;
  word_arr_t lo_q;
  word_arr_t hi_q;
  flags_t    flags;
  status_t   status;
  match_t    match;

  // Stage handshake: stage 1 moves whenever the result register is free.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req <= '{is_v6: is_v6, addr_low: addr_low, addr_high: addr_high};
    end
  end

  dfas_match u_match (
    .req   (s1_req),
    .lo_q  (lo_q),
    .hi_q  (hi_q),
    .flags (flags),
    .used  (status.used),
    .match (match)
  );

  dfas_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (s1_adv && !match.hit),
    .req    (s1_req),
    .lo_q   (lo_q),
    .hi_q   (hi_q),
    .flags  (flags),
    .status (status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      added <= !match.hit;
      if (match.hit) begin
        slot        <= OUT_SLOT_W'(match.idx);
        valid_count <= OUT_COUNT_W'(status.used);
      end else begin
        slot        <= OUT_SLOT_W'(status.next_slot);
        valid_count <= OUT_COUNT_W'(status.used_after_add);
      end
    end
  end

endmodule

@@ design/dfas_checker.sv @@
// Port-level checks for the dual-family address set, bound to the top level.
module dfas_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             added,
  input logic [dfas_pkg::OUT_SLOT_W-1:0]  slot,
  input logic [dfas_pkg::OUT_COUNT_W-1:0] valid_count
);
  import dfas_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(added) && $stable(slot)
      && $stable(valid_count))
    else $error("result changed while stalled");

  // Any result leaves at least one and at most SLOTS valid slots.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> valid_count != '0 && valid_count <= OUT_COUNT_W'(SLOTS))
    else $error("valid_count out of range");

  // A duplicate always points inside the valid region.
  a_dup_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !added |-> OUT_COUNT_W'(slot) < valid_count)
    else $error("duplicate slot beyond valid slots");

  // Before the set is full, a store lands at the newest valid slot.
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && added && valid_count < OUT_COUNT_W'(SLOTS)
      |-> OUT_COUNT_W'(slot) + 1'b1 == valid_count)
    else $error("store not in fill order");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dual_family_address_set dfas_checker u_dfas_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .added       (added),
  .slot        (slot),
  .valid_count (valid_count)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the dual-family address set: predicts every result and compares.
module testbench;
  import dfas_pkg::*;

  localparam int ITEMS      = 1000;
  localparam int TAIL_ITEMS = 150;
  localparam int LONG_HOLD  = 80;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 12;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   is_v6;
  word_t                  addr_low;
  word_t                  addr_high;
  logic                   out_valid;
  logic                   out_ready;
  logic                   added;
  logic [OUT_SLOT_W-1:0]  slot;
  logic [OUT_COUNT_W-1:0] valid_count;

  // Idle controls shared between the sender and the receiver
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  // Recently offered addresses, reused to provoke duplicate hits
  req_t recent_q[$];

  typedef struct {
    logic                   added;
    logic [OUT_SLOT_W-1:0]  slot;
    logic [OUT_COUNT_W-1:0] count;
  } outcome_t;

  // Scoreboard: mirrors the slot store and queues the outcome of each request
  class addr_set_scoreboard;
    word_t       lo_store[SLOTS];
    word_t       hi_store[SLOTS];
    flags_t      v6_flags;
    int unsigned wr_ptr;
    int unsigned fill;
    outcome_t    pending_outcomes[$];
    int unsigned errors;
    int unsigned n_req;
    int unsigned n_added;
    int unsigned n_dup;
    int unsigned n_overwrite;

    function new();
      v6_flags    = '0;
      wr_ptr      = 0;
      fill        = 0;
      errors      = 0;
      n_req       = 0;
      n_added     = 0;
      n_dup       = 0;
      n_overwrite = 0;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    // Lookup among valid slots, insert at the round-robin pointer on a miss
    function void note_request(logic v6, word_t lo, word_t hi);
      outcome_t o;
      bit       hit;
      int       i;
      hit = 0;
      for (i = 0; i < int'(fill); i++) begin
        if (!hit && v6_flags[i] == v6 &&
            (v6 ? (lo_store[i] == lo && hi_store[i] == hi)
                : (lo_store[i][V4_W-1:0] == lo[V4_W-1:0]))) begin
          hit    = 1;
          o.slot = OUT_SLOT_W'(i);
        end
      end
      n_req++;
      if (hit) begin
        o.added = 1'b0;
        o.count = OUT_COUNT_W'(fill);
        n_dup++;
      end else begin
        if (v6) begin
          lo_store[wr_ptr]  = lo;
          hi_store[wr_ptr]  = hi;
          v6_flags[wr_ptr]  = 1'b1;
        end else begin
          lo_store[wr_ptr]  = {32'h0, lo[V4_W-1:0]};
          hi_store[wr_ptr]  = '0;
          v6_flags[wr_ptr]  = 1'b0;
        end
        o.added = 1'b1;
        o.slot  = OUT_SLOT_W'(wr_ptr);
        wr_ptr  = (wr_ptr + 1 >= SLOTS) ? 0 : wr_ptr + 1;
        if (fill < SLOTS) fill++;
        else n_overwrite++;
        o.count = OUT_COUNT_W'(fill);
        n_added++;
      end
      pending_outcomes.push_back(o);
    endfunction

    // Compare one accepted result with the oldest outcome
    function void check_result(logic a, logic [OUT_SLOT_W-1:0] s, logic [OUT_COUNT_W-1:0] c);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result added=%0d slot=%0d valid_count=%0d",
                 $time, a, s, c);
        return;
      end
      o = pending_outcomes.pop_front();
      if (a !== o.added) begin
        errors++;
        $display("%0t: added expected %0d actual %0d", $time, o.added, a);
      end
      if (s !== o.slot) begin
        errors++;
        $display("%0t: slot expected %0d actual %0d", $time, o.slot, s);
      end
      if (c !== o.count) begin
        errors++;
        $display("%0t: valid_count expected %0d actual %0d", $time, o.count, c);
      end
    endfunction
  endclass

  addr_set_scoreboard sb;

  dual_family_address_set u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .is_v6       (is_v6),
    .addr_low    (addr_low),
    .addr_high   (addr_high),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .added       (added),
    .slot        (slot),
    .valid_count (valid_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: results are checked before the same edge's request is noted
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (out_valid && out_ready) sb.check_result(added, slot, valid_count);
      if (in_valid && in_ready) sb.note_request(is_v6, addr_low, addr_high);
    end
  end

  // Watchdog on cycles with no handshake on either side
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one address; entered and left at a falling edge
  task automatic send_addr(input logic v6, input word_t lo, input word_t hi);
    int   n;
    req_t r;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid  <= 1'b1;
    is_v6     <= v6;
    addr_low  <= lo;
    addr_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    r.is_v6     = v6;
    r.addr_low  = lo;
    r.addr_high = hi;
    recent_q.push_back(r);
    if (recent_q.size() > 24) void'(recent_q.pop_front());
  endtask

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Random address, biased toward recent ones so that hits and near misses are common
  function automatic req_t random_addr();
    req_t r;
    int   pick;
    int   b;
    pick = $urandom_range(0, 99);
    if (recent_q.size() > 0 && pick < 55) begin
      r = recent_q[$urandom_range(0, recent_q.size() - 1)];
      if (pick >= 35 && pick < 45) begin
        // same family, touch bits that matter only for IPv6 or only the ignored ones
        if (r.is_v6) begin
          b = $urandom_range(0, 127);
          if (b < 64) r.addr_low[b] = ~r.addr_low[b];
          else r.addr_high[b - 64] = ~r.addr_high[b - 64];
        end else begin
          r.addr_low[63:32] = $urandom();
          r.addr_high       = rand_word();
        end
      end else if (pick >= 45) begin
        // same bits, other family
        r.is_v6 = ~r.is_v6;
      end
    end else if (pick < 70) begin
      r.is_v6     = 1'($urandom_range(0, 1));
      r.addr_low  = {$urandom(), 29'h0, 3'($urandom_range(0, 7))};
      r.addr_high = 64'($urandom_range(0, 1));
      if (!r.is_v6 && $urandom_range(0, 1) == 0) r.addr_low[63:32] = '0;
      if (r.is_v6) r.addr_low[63:32] = 32'($urandom_range(0, 1));
    end else begin
      r.is_v6     = 1'($urandom_range(0, 1));
      r.addr_low  = rand_word();
      r.addr_high = rand_word();
    end
    return r;
  endfunction

  // Main sequence
  initial begin
    req_t r;
    int   k;
    rst        = 1'b1;
    in_valid   = 1'b0;
    is_v6      = 1'b0;
    addr_low   = '0;
    addr_high  = '0;
    tx_idle_on = 1;
    rx_idle_on = 1;
    hold_req   = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, ignored bits, family separation, fill, saturation and wrap
    send_addr(1'b0, 64'h0, 64'h0);
    send_addr(1'b0, 64'h0, 64'h0);
    send_addr(1'b0, '1, '1);
    send_addr(1'b0, 64'h0000_0000_FFFF_FFFF, 64'h0);
    send_addr(1'b1, 64'h0, 64'h0);
    send_addr(1'b1, 64'h0, 64'h0);
    send_addr(1'b1, '1, '1);
    send_addr(1'b1, '1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_addr(1'b1, 64'h0000_0000_FFFF_FFFF, 64'h0);
    send_addr(1'b0, 64'hA5A5_A5A5_FFFF_FFFF, 64'h1234);
    for (k = 1; k <= 10; k++) send_addr(1'b0, 64'(k), 64'h0);
    send_addr(1'b0, 64'd11, 64'h0);
    send_addr(1'b0, 64'h0, 64'h0);
    send_addr(1'b1, '1, '1);
    send_addr(1'b0, 64'd5, '1);

    // Random traffic in segments with different idle settings
    for (k = 0; k < ITEMS; k++) begin
      if (k % 100 == 0 && k < ITEMS - TAIL_ITEMS) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      if (k == ITEMS - TAIL_ITEMS) begin
        tx_idle_on = 0;
        rx_idle_on = 0;
      end
      if (k == 300) begin
        // long receiver hold-off while requests keep coming
        tx_idle_on = 0;
        hold_req   = 1;
      end
      if (k == 550) begin
        // sender waits for every outstanding result
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
      r = random_addr();
      send_addr(r.is_v6, r.addr_low, r.addr_high);
    end
    in_valid <= 1'b0;

    // Drain, then give late or extra results time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Offered %0d addresses: %0d stored, %0d duplicates, %0d overwrites of a full set",
             sb.n_req, sb.n_added, sb.n_dup, sb.n_overwrite);
    $display("Included a long receiver hold-off, a drain pause and idle bursts on both sides");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/dfas_pkg.sv
design/dfas_match.sv
design/dfas_store.sv
design/dual_family_address_set.sv
design/dfas_checker.sv
tb/testbench.sv
